[sv/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants and a width helper for the matrix to quaternion core.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int DATA_W        = 16;
   localparam int LANES         = 4;
   localparam int SAT_MAG       = 32768;
   localparam int SAT_POS       = 32767;

   // magnitude width of one unnormalized component (s or an off-diagonal term)
   function automatic int vec_w(input int frac);
      return ((frac > 17) ? frac : 17) + 1;
   endfunction

endpackage

[sv/rmq_if.sv]
// ----------------------------------------------------------------------------
// rmq_req_if / rmq_rsp_if
// Valid/ready channels carrying one matrix and one quaternion per transaction.
// ----------------------------------------------------------------------------
interface rmq_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [rmq_pkg::DATA_W-1:0]   m00, m01, m02, m10, m11, m12, m20, m21, m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   output ready);
endinterface

interface rmq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rmq_pkg::DATA_W-1:0]   quat_w, quat_x, quat_y, quat_z;
   logic                                no_case_error;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, no_case_error,
                   input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, no_case_error,
                   output ready);
endinterface

[sv/rmq_front.sv]
// ----------------------------------------------------------------------------
// rmq_front
// Case selection, component magnitudes, squares and sum of squares, 4 stages.
// ----------------------------------------------------------------------------
module rmq_front #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  logic                                      in_valid,
   input  logic signed [rmq_pkg::DATA_W-1:0]         m00, m01, m02,
   input  logic signed [rmq_pkg::DATA_W-1:0]         m10, m11, m12,
   input  logic signed [rmq_pkg::DATA_W-1:0]         m20, m21, m22,
   output logic                                      out_valid,
   output logic                                      out_err,
   output logic [rmq_pkg::LANES-1:0]                 out_neg,
   output logic [rmq_pkg::LANES-1:0][rmq_pkg::vec_w(FRAC_BITS)-1:0] out_mag,
   output logic [2*rmq_pkg::vec_w(FRAC_BITS)+1:0]    out_sumsq
);
   localparam int VW  = rmq_pkg::vec_w(FRAC_BITS);
   localparam int SVW = VW + 1;
   localparam int PW  = 2 * VW;
   localparam int SQW = 2 * VW + 2;
   localparam int L   = rmq_pkg::LANES;

   logic signed [SVW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, one_s;
   logic signed [SVW-1:0] v_in [L];
   logic                  err_in;

   assign e00 = SVW'(m00);  assign e01 = SVW'(m01);  assign e02 = SVW'(m02);
   assign e10 = SVW'(m10);  assign e11 = SVW'(m11);  assign e12 = SVW'(m12);
   assign e20 = SVW'(m20);  assign e21 = SVW'(m21);  assign e22 = SVW'(m22);
   assign one_s = SVW'(1) << FRAC_BITS;

   always_comb begin
      err_in = 1'b0;
      for (int i = 0; i < L; i++) v_in[i] = '0;
      priority if (e11 >= -e22 && e00 >= -e11 && e00 >= -e22) begin
         v_in[0] = one_s + e00 + e11 + e22;
         v_in[1] = e12 - e21;
         v_in[2] = e20 - e02;
         v_in[3] = e01 - e10;
      end else if (e11 <= -e22 && e00 >= e11 && e00 >= e22) begin
         v_in[0] = e12 - e21;
         v_in[1] = one_s + e00 - e11 - e22;
         v_in[2] = e01 + e10;
         v_in[3] = e20 + e02;
      end else if (e11 >= e22 && e00 <= e11 && e00 <= -e22) begin
         v_in[0] = e20 - e02;
         v_in[1] = e01 + e10;
         v_in[2] = one_s - e00 + e11 - e22;
         v_in[3] = e12 + e21;
      end else if (e11 <= e22 && e00 <= -e11 && e00 <= e22) begin
         v_in[0] = e01 - e10;
         v_in[1] = e20 + e02;
         v_in[2] = e12 + e21;
         v_in[3] = one_s - e00 - e11 + e22;
      end else begin
         err_in = 1'b1;
      end
   end

   // stage 1: selected vector
   logic                  s1_valid_ff, s1_err_ff;
   logic signed [SVW-1:0] s1_v_ff [L];
   // stage 2: magnitudes and squares
   logic                  s2_valid_ff, s2_err_ff;
   logic [L-1:0]          s2_neg_ff;
   logic [L-1:0][VW-1:0]  s2_mag_ff;
   logic [PW-1:0]         s2_sq_ff [L];
   // stage 3: pair sums
   logic                  s3_valid_ff, s3_err_ff;
   logic [L-1:0]          s3_neg_ff;
   logic [L-1:0][VW-1:0]  s3_mag_ff;
   logic [PW:0]           s3_pair_ff [2];
   // stage 4: total
   logic                  s4_valid_ff, s4_err_ff;
   logic [L-1:0]          s4_neg_ff;
   logic [L-1:0][VW-1:0]  s4_mag_ff;
   logic [SQW-1:0]        s4_sum_ff;

   logic [L-1:0][VW-1:0]  mag_in;
   logic [L-1:0]          neg_in;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         neg_in[i] = s1_v_ff[i][SVW-1];
         mag_in[i] = neg_in[i] ? VW'(-s1_v_ff[i]) : VW'(s1_v_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_err_ff <= err_in;
         s1_v_ff   <= v_in;
         s2_err_ff <= s1_err_ff;
         s2_neg_ff <= neg_in;
         s2_mag_ff <= mag_in;
         for (int i = 0; i < L; i++) s2_sq_ff[i] <= PW'(mag_in[i]) * PW'(mag_in[i]);
         s3_err_ff     <= s2_err_ff;
         s3_neg_ff     <= s2_neg_ff;
         s3_mag_ff     <= s2_mag_ff;
         s3_pair_ff[0] <= (PW+1)'(s2_sq_ff[0]) + (PW+1)'(s2_sq_ff[1]);
         s3_pair_ff[1] <= (PW+1)'(s2_sq_ff[2]) + (PW+1)'(s2_sq_ff[3]);
         s4_err_ff <= s3_err_ff;
         s4_neg_ff <= s3_neg_ff;
         s4_mag_ff <= s3_mag_ff;
         s4_sum_ff <= SQW'(s3_pair_ff[0]) + SQW'(s3_pair_ff[1]);
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_err   = s4_err_ff;
   assign out_neg   = s4_neg_ff;
   assign out_mag   = s4_mag_ff;
   assign out_sumsq = s4_sum_ff;
endmodule

[sv/rmq_sqrt.sv]
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
   parameter int IN_W   = 38,
   parameter int SIDE_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [IN_W-1:0]     rad,
   input  logic [SIDE_W-1:0]   side_in,
   output logic                out_valid,
   output logic [IN_W/2-1:0]   root,
   output logic [SIDE_W-1:0]   side_out
);
   localparam int NB = IN_W / 2;
   localparam int RW = NB + 2;

   logic              valid_ff [NB];
   logic [RW-1:0]     rem_ff   [NB];
   logic [NB-1:0]     root_ff  [NB];
   logic [IN_W-1:0]   rad_ff   [NB];
   logic [SIDE_W-1:0] side_ff  [NB];

   for (genvar k = 0; k < NB; k++) begin : g_stage
      logic              v_p;
      logic [RW-1:0]     rem_p;
      logic [NB-1:0]     root_p;
      logic [IN_W-1:0]   rad_p;
      logic [SIDE_W-1:0] side_p;
      logic [RW+1:0]     sh, trial;

      if (k == 0) begin : g_first
         assign v_p    = in_valid;
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = rad;
         assign side_p = side_in;
      end else begin : g_next
         assign v_p    = valid_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rad_p  = rad_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign sh    = {rem_p, rad_p[IN_W-1 -: 2]};
      assign trial = (RW+2)'({root_p, 2'b01});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (sh >= trial) begin
               rem_ff[k]  <= RW'(sh - trial);
               root_ff[k] <= {root_p[NB-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= RW'(sh);
               root_ff[k] <= {root_p[NB-2:0], 1'b0};
            end
            rad_ff[k]  <= rad_p << 2;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = valid_ff[NB-1];
   assign root      = root_ff[NB-1];
   assign side_out  = side_ff[NB-1];
endmodule

[sv/rmq_div.sv]
// ----------------------------------------------------------------------------
// rmq_div
// Four-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module rmq_div #(
   parameter int DEN_W  = 19,
   parameter int QB     = 15,
   parameter int SIDE_W = 5
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  logic                                      in_valid,
   input  logic [rmq_pkg::LANES-1:0][DEN_W+QB-1:0]   num,
   input  logic [DEN_W-1:0]                          den,
   input  logic [SIDE_W-1:0]                         side_in,
   output logic                                      out_valid,
   output logic [rmq_pkg::LANES-1:0][QB-1:0]         quo,
   output logic [SIDE_W-1:0]                         side_out
);
   localparam int L = rmq_pkg::LANES;

   logic                       valid_ff [QB];
   logic [L-1:0][DEN_W-1:0]    rem_ff   [QB];
   logic [L-1:0][QB-1:0]       low_ff   [QB];
   logic [L-1:0][QB-1:0]       q_ff     [QB];
   logic [DEN_W-1:0]           den_ff   [QB];
   logic [SIDE_W-1:0]          side_ff  [QB];

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic                    v_p;
      logic [L-1:0][DEN_W-1:0] rem_p, rem_n;
      logic [L-1:0][QB-1:0]    low_p, q_p, q_n;
      logic [DEN_W-1:0]        den_p;
      logic [SIDE_W-1:0]       side_p;
      logic [DEN_W:0]          sh [L];

      if (k == 0) begin : g_first
         assign v_p    = in_valid;
         assign den_p  = den;
         assign side_p = side_in;
         assign q_p    = '0;
         for (genvar l = 0; l < L; l++) begin : g_lane
            // upper part is below the divisor since the quotient fits QB bits
            assign rem_p[l] = num[l][DEN_W+QB-1:QB];
            assign low_p[l] = num[l][QB-1:0];
         end
      end else begin : g_next
         assign v_p    = valid_ff[k-1];
         assign den_p  = den_ff[k-1];
         assign side_p = side_ff[k-1];
         assign q_p    = q_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign low_p  = low_ff[k-1];
      end

      always_comb begin
         for (int l = 0; l < L; l++) begin
            sh[l] = {rem_p[l], low_p[l][QB-1]};
            if (sh[l] >= {1'b0, den_p}) begin
               rem_n[l] = DEN_W'(sh[l] - {1'b0, den_p});
               q_n[l]   = {q_p[l][QB-2:0], 1'b1};
            end else begin
               rem_n[l] = DEN_W'(sh[l]);
               q_n[l]   = {q_p[l][QB-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_n;
            q_ff[k]    <= q_n;
            for (int l = 0; l < L; l++) low_ff[k][l] <= low_p[l] << 1;
            den_ff[k]  <= den_p;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign quo       = q_ff[QB-1];
   assign side_out  = side_ff[QB-1];
endmodule

[sv/rotation_matrix_to_quaternion_core.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Rotation matrix to unit quaternion, Shepperd case selection, fixed point.
// ----------------------------------------------------------------------------
// Takes one 3x3 rotation matrix per transaction and returns the unit
// quaternion (conjugate convention) in the same fixed-point format, with
// no_case_error set and a zero quaternion when no case applies. The block is
// a full pipeline: it accepts one matrix every cycle while the result channel is
// not stalled. It consists of four front stages (case select, squares, sum),
// the square root at one root bit per stage, one scaling stage, the four-lane
// divider at one quotient bit per stage, and the output register. A stalled
// result channel holds the whole pipeline.
module rotation_matrix_to_quaternion_core #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   rmq_req_if.sink   req_if,
   rmq_rsp_if.source rsp_if
);
   localparam int VW     = rmq_pkg::vec_w(FRAC_BITS);
   localparam int SQW    = 2 * VW + 2;
   localparam int NB     = SQW / 2;
   localparam int QB     = FRAC_BITS + 1;
   localparam int NUM_W  = NB + QB;
   localparam int L      = rmq_pkg::LANES;
   localparam int DW     = rmq_pkg::DATA_W;
   localparam int SQ_SW  = 1 + L + L * VW;
   localparam int DIV_SW = 1 + L;
   localparam int QW     = QB + 17;

   logic en;
   logic out_valid_ff;

   assign en           = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = en;

   // front
   logic                 f_valid, f_err;
   logic [L-1:0]         f_neg;
   logic [L-1:0][VW-1:0] f_mag;
   logic [SQW-1:0]       f_sumsq;

   rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_if.valid),
      .m00 (req_if.m00), .m01 (req_if.m01), .m02 (req_if.m02),
      .m10 (req_if.m10), .m11 (req_if.m11), .m12 (req_if.m12),
      .m20 (req_if.m20), .m21 (req_if.m21), .m22 (req_if.m22),
      .out_valid (f_valid),
      .out_err   (f_err),
      .out_neg   (f_neg),
      .out_mag   (f_mag),
      .out_sumsq (f_sumsq)
   );

   // norm
   logic                 r_valid;
   logic [NB-1:0]        r_norm;
   logic [SQ_SW-1:0]     r_side;
   logic                 r_err;
   logic [L-1:0]         r_neg;
   logic [L-1:0][VW-1:0] r_mag;

   rmq_sqrt #(.IN_W(SQW), .SIDE_W(SQ_SW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .rad       (f_sumsq),
      .side_in   ({f_err, f_neg, f_mag}),
      .out_valid (r_valid),
      .root      (r_norm),
      .side_out  (r_side)
   );

   assign {r_err, r_neg, r_mag} = r_side;

   // numerator = mag * ONE + norm/2 for round-half-up of the quotient
   logic                    p_valid_ff, p_err_ff;
   logic [L-1:0]            p_neg_ff;
   logic [L-1:0][NUM_W-1:0] p_num_ff;
   logic [NB-1:0]           p_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= r_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_err_ff <= r_err;
         p_neg_ff <= r_neg;
         p_den_ff <= r_norm;
         for (int l = 0; l < L; l++) begin
            p_num_ff[l] <= (NUM_W'(r_mag[l]) << FRAC_BITS) + NUM_W'(r_norm >> 1);
         end
      end
   end

   // divide
   logic                 d_valid;
   logic [L-1:0][QB-1:0] d_quo;
   logic [DIV_SW-1:0]    d_side;
   logic                 d_err;
   logic [L-1:0]         d_neg;

   rmq_div #(.DEN_W(NB), .QB(QB), .SIDE_W(DIV_SW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_valid_ff),
      .num       (p_num_ff),
      .den       (p_den_ff),
      .side_in   ({p_err_ff, p_neg_ff}),
      .out_valid (d_valid),
      .quo       (d_quo),
      .side_out  (d_side)
   );

   assign {d_err, d_neg} = d_side;

   // saturate, apply sign, output register
   logic signed [DW-1:0] comp_in [L];
   logic [QW-1:0]        qx;
   logic [16:0]          qs;

   always_comb begin
      qx = '0;
      qs = '0;
      for (int l = 0; l < L; l++) begin
         qx = QW'(d_quo[l]);
         qs = (qx > QW'(rmq_pkg::SAT_MAG)) ? 17'(rmq_pkg::SAT_MAG) : 17'(qx);
         if (d_err) begin
            comp_in[l] = '0;
         end else if (d_neg[l]) begin
            comp_in[l] = DW'(-$signed({1'b0, qs}));
         end else if (qs > 17'(rmq_pkg::SAT_POS)) begin
            comp_in[l] = DW'(rmq_pkg::SAT_POS);
         end else begin
            comp_in[l] = DW'(qs);
         end
      end
   end

   logic signed [DW-1:0] w_ff, x_ff, y_ff, z_ff;
   logic                 err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff   <= comp_in[0];
         x_ff   <= comp_in[1];
         y_ff   <= comp_in[2];
         z_ff   <= comp_in[3];
         err_ff <= d_err;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.quat_w        = w_ff;
   assign rsp_if.quat_x        = x_ff;
   assign rsp_if.quat_y        = y_ff;
   assign rsp_if.quat_z        = z_ff;
   assign rsp_if.no_case_error = err_ff;
endmodule

[verif/rmq_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_tb_if
// Testbench side notes for the matrix to quaternion channels.
// ----------------------------------------------------------------------------
// The channel interfaces come from the design sources; this file only carries
// the matrix and quaternion records the stimulus, predictor and checker share.
package rmq_tb_pkg;
   typedef struct {
      logic signed [15:0] m [9];
   } matrix_type;

   typedef struct {
      logic signed [15:0] w, x, y, z;
      logic               err;
   } quat_type;
endpackage

[verif/rotation_matrix_to_quaternion_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core_tb
// Self-checking bench for the matrix to quaternion core.
// ----------------------------------------------------------------------------
// Drives directed and random matrices through the request channel, predicts
// each quaternion with an integer model of the Shepperd scheme and compares
// results in order, under several sender and receiver idling mixes.
module rotation_matrix_to_quaternion_core_tb;

   localparam int FB  = rmq_pkg::FRAC_BITS_DEF;
   localparam int LAT = ((FB > 17) ? FB : 17) + FB + 9;

   logic clock;
   logic reset;

   rmq_req_if req_if ();
   rmq_rsp_if rsp_if ();

   rotation_matrix_to_quaternion_core #(.FRAC_BITS(FB)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   rmq_tb_pkg::quat_type quat_queue[$];
   int    mismatches;
   int    send_idle_pct;
   int    stall_pct;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("rotation_matrix_to_quaternion_core verification failed");
      $finish;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res;
      longint unsigned bit_v;
      res   = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n   -= res + bit_v;
            res  = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [15:0] scale_lane(input longint v,
                                                     input longint unsigned norm);
      longint unsigned mag;
      longint unsigned q;
      longint          r;
      mag = (v < 0) ? longint'(-v) : longint'(v);
      q   = ((mag << FB) + (norm >> 1)) / norm;
      if (q > rmq_pkg::SAT_MAG) q = rmq_pkg::SAT_MAG;
      r = (v < 0) ? -longint'(q) : longint'(q);
      if (r > rmq_pkg::SAT_POS) r = rmq_pkg::SAT_POS;
      return r[15:0];
   endfunction

   function automatic rmq_tb_pkg::quat_type predict_quat(input rmq_tb_pkg::matrix_type mx);
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22, one;
      longint v[4];
      longint unsigned sumsq, norm, mg;
      rmq_tb_pkg::quat_type q;
      a00 = mx.m[0]; a01 = mx.m[1]; a02 = mx.m[2];
      a10 = mx.m[3]; a11 = mx.m[4]; a12 = mx.m[5];
      a20 = mx.m[6]; a21 = mx.m[7]; a22 = mx.m[8];
      one = longint'(1) << FB;
      q = '{default: '0};
      if (a11 >= -a22 && a00 >= -a11 && a00 >= -a22) begin
         v = '{one + a00 + a11 + a22, a12 - a21, a20 - a02, a01 - a10};
      end else if (a11 <= -a22 && a00 >= a11 && a00 >= a22) begin
         v = '{a12 - a21, one + a00 - a11 - a22, a01 + a10, a20 + a02};
      end else if (a11 >= a22 && a00 <= a11 && a00 <= -a22) begin
         v = '{a20 - a02, a01 + a10, one - a00 + a11 - a22, a12 + a21};
      end else if (a11 <= a22 && a00 <= -a11 && a00 <= a22) begin
         v = '{a01 - a10, a20 + a02, a12 + a21, one - a00 - a11 + a22};
      end else begin
         q.err = 1'b1;
         return q;
      end
      sumsq = 0;
      for (int i = 0; i < 4; i++) begin
         mg     = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
         sumsq += mg * mg;
      end
      norm = int_sqrt(sumsq);
      if (norm != 0) begin
         q.w = scale_lane(v[0], norm);
         q.x = scale_lane(v[1], norm);
         q.y = scale_lane(v[2], norm);
         q.z = scale_lane(v[3], norm);
      end
      return q;
   endfunction

   // receiver: random stall, checks every accepted transaction
   always @(negedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else       rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      rmq_tb_pkg::quat_type exp_q;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (quat_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected quaternion at %0t", $time);
         end else begin
            exp_q = quat_queue.pop_front();
            if (rsp_if.quat_w !== exp_q.w || rsp_if.quat_x !== exp_q.x ||
                rsp_if.quat_y !== exp_q.y || rsp_if.quat_z !== exp_q.z ||
                rsp_if.no_case_error !== exp_q.err) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: exp %0d %0d %0d %0d err %0b,",
                           $time, exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.err,
                           " got %0d %0d %0d %0d err %0b",
                           rsp_if.quat_w, rsp_if.quat_x, rsp_if.quat_y, rsp_if.quat_z,
                           rsp_if.no_case_error);
            end
         end
      end
   end

   // valid stays up between back to back transactions
   task automatic send_matrix(input rmq_tb_pkg::matrix_type mx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.m00 <= mx.m[0]; req_if.m01 <= mx.m[1]; req_if.m02 <= mx.m[2];
      req_if.m10 <= mx.m[3]; req_if.m11 <= mx.m[4]; req_if.m12 <= mx.m[5];
      req_if.m20 <= mx.m[6]; req_if.m21 <= mx.m[7]; req_if.m22 <= mx.m[8];
      do @(posedge clock); while (!req_if.ready);
      quat_queue.push_back(predict_quat(mx));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (quat_queue.size() != 0) @(negedge clock);
   endtask

   function automatic rmq_tb_pkg::matrix_type diag_matrix(input int d0, input int d1,
                                                          input int d2, input int off);
      rmq_tb_pkg::matrix_type mx;
      for (int i = 0; i < 9; i++) mx.m[i] = 16'(off * (i + 1));
      mx.m[0] = 16'(d0); mx.m[4] = 16'(d1); mx.m[8] = 16'(d2);
      return mx;
   endfunction

   // a rotation-like matrix: signed diagonal picked to steer the case
   function automatic rmq_tb_pkg::matrix_type rotation_like();
      rmq_tb_pkg::matrix_type mx;
      int      sel;
      for (int i = 0; i < 9; i++) mx.m[i] = 16'($urandom_range(32768) - 16384);
      sel = $urandom_range(3);
      mx.m[0] = 16'((sel == 0 || sel == 1) ? $urandom_range(16384) : -$urandom_range(16384));
      mx.m[4] = 16'((sel == 0 || sel == 2) ? $urandom_range(16384) : -$urandom_range(16384));
      mx.m[8] = 16'((sel == 0 || sel == 3) ? $urandom_range(16384) : -$urandom_range(16384));
      return mx;
   endfunction

   task automatic test_directed();
      rmq_tb_pkg::matrix_type mx;
      send_matrix(diag_matrix(16384, 16384, 16384, 0));     // identity
      send_matrix(diag_matrix(16384, -16384, -16384, 0));   // x axis flip
      send_matrix(diag_matrix(-16384, 16384, -16384, 0));   // y axis flip
      send_matrix(diag_matrix(-16384, -16384, 16384, 0));   // z axis flip
      send_matrix(diag_matrix(32767, 32767, 32767, 0));
      send_matrix(diag_matrix(-32768, -32768, -32768, 0));
      send_matrix(diag_matrix(-32768, 32767, -32768, 5));
      send_matrix(diag_matrix(32767, -32768, 32767, -7));
      send_matrix(diag_matrix(0, 0, 0, 0));
      // mixed-sign diagonals close to the case boundaries
      send_matrix(diag_matrix(-100, 50, 60, 3));
      send_matrix(diag_matrix(100, -300, 250, 1));
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 9; i++) mx.m[i] = (k[0]) ? 16'h7fff : 16'h8000;
         if (k[1]) begin
            mx.m[0] = 16'h8000; mx.m[8] = 16'h7fff;
         end
         send_matrix(mx);
      end
      for (int i = 0; i < 9; i++) mx.m[i] = 16'(i[0] ? 32767 : -32768);
      send_matrix(mx);
      for (int i = 0; i < 9; i++) mx.m[i] = 16'(i[0] ? -32768 : 32767);
      send_matrix(mx);
      wait_drained();
   endtask

   task automatic test_random(input int count, input int idle, input int stall);
      rmq_tb_pkg::matrix_type mx;
      send_idle_pct = idle;
      stall_pct     = stall;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) < 7) begin
            mx = rotation_like();
         end else begin
            for (int i = 0; i < 9; i++) mx.m[i] = 16'($urandom);
         end
         send_matrix(mx);
      end
   endtask

   task automatic test_drain_pause();
      wait_drained();
      test_random(20, 0, 0);
   endtask

   initial begin
      reset         = 1'b1;
      mismatches    = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      req_if.valid  = 1'b0;
      {req_if.m00, req_if.m01, req_if.m02} = '0;
      {req_if.m10, req_if.m11, req_if.m12} = '0;
      {req_if.m20, req_if.m21, req_if.m22} = '0;
      rsp_if.ready  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(140, 0, 0);
      test_random(130, 59, 0);
      test_random(130, 0, 59);
      test_drain_pause();
      test_random(130, 15, 15);
      send_idle_pct = 0;
      stall_pct     = 0;

      wait_drained();
      repeat (LAT + 10) @(negedge clock);
      if (mismatches == 0 && quat_queue.size() == 0) begin
         $display("rotation_matrix_to_quaternion_core verification clean");
      end else begin
         $display("rotation_matrix_to_quaternion_core verification failed");
      end
      $finish;
   end
endmodule

[sim.f]
sv/rmq_pkg.sv
sv/rmq_if.sv
sv/rmq_front.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion_core.sv
verif/rmq_tb_if.sv
verif/rotation_matrix_to_quaternion_core_tb.sv
